FILE: hdl/iapsp_pkg.sv
// Shared types, constants and saturating arithmetic for the incremental shortest-path block.
package iapsp_pkg;

    localparam int DIST_W = 22;
    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
    localparam int NODE_CNT_W = 7;
    localparam logic [NODE_CNT_W-1:0] NODE_CNT_RESET = 7'd64;

    // Operation codes carried by the operation field.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    typedef logic [DIST_W-1:0] t_dist;

    // Per-cycle command broadcast to every cell.
    typedef enum logic [2:0] {
        C_NOP   = 3'd0,
        C_ADD   = 3'd1,
        C_LOADR = 3'd2,
        C_LOADC = 3'd3,
        C_P1    = 3'd4,
        C_P2    = 3'd5,
        C_P3    = 3'd6,
        C_SHIFT = 3'd7
    } t_cop;

    typedef struct packed {
        t_cop  op;
        t_dist sa;
        t_dist sb;
        logic  skip;
        logic  u_new;
        logic  u_act;
    } t_cell_ctl;

    function automatic t_dist sat_add(input t_dist a, input t_dist b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, DIST_INF}) ? DIST_INF : s[DIST_W-1:0];
    endfunction

    function automatic t_dist dmin(input t_dist a, input t_dist b);
        return (b < a) ? b : a;
    endfunction

endpackage

FILE: hdl/iapsp_lane_mem.sv
// Row-wide memory with per-lane write mask and registered read.
module iapsp_lane_mem import iapsp_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int LANES = 64,
    parameter int DW    = 22,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [LANES-1:0]           i_wmask,
    input  logic [LANES-1:0][DW-1:0]   i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [LANES-1:0][DW-1:0]   o_rdata
);

    logic [LANES-1:0][DW-1:0] r_mem [DEPTH];
    logic [LANES-1:0][DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int l = 0; l < LANES; l++) begin
                if (i_wmask[l]) begin
                    r_mem[i_waddr][l] <= i_wdata[l];
                end
            end
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/iapsp_cell.sv
// One vertex cell: holds its column and row distance to the new vertex and a running max.
module iapsp_cell import iapsp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_sel,
    input  logic      i_is_new,
    input  t_dist     i_lane_a,
    input  t_dist     i_lane_b,
    input  t_dist     i_mx_prev,
    output t_dist     o_c,
    output t_dist     o_r,
    output t_dist     o_mx,
    output logic      o_act,
    output t_dist     o_row_new,
    output t_dist     o_col_new
);

    t_dist r_c;
    t_dist r_r;
    t_dist r_mx;
    logic  r_act;
    t_dist sum1;
    t_dist relax_c;
    t_dist relax_r;
    t_dist base_r;
    t_dist base_c;
    t_dist row_new;
    t_dist col_new;

    always_comb begin
        sum1    = sat_add(i_lane_a, i_ctl.sa);
        relax_c = dmin(r_c, sum1);
        relax_r = dmin(r_r, sum1);
        base_r  = i_ctl.u_new ? r_r : (i_is_new ? i_ctl.sa : i_lane_a);
        base_c  = i_ctl.u_new ? r_c : (i_is_new ? i_ctl.sb : i_lane_b);
        row_new = dmin(base_r, sat_add(i_ctl.sa, r_r));
        col_new = dmin(base_c, sat_add(r_c, i_ctl.sb));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (i_ctl.op == C_ADD && i_sel) begin
            r_act <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            C_ADD: begin
                r_mx <= '0;
            end
            C_LOADR: begin
                r_r <= i_lane_a;
                if (i_is_new) begin
                    r_c <= i_lane_a;
                end
            end
            C_LOADC: begin
                if (i_sel) begin
                    r_c <= i_ctl.sa;
                end
            end
            C_P1: begin
                if (r_act && !i_ctl.skip) begin
                    r_c <= relax_c;
                    if (i_is_new) begin
                        r_r <= relax_c;
                    end
                end
            end
            C_P2: begin
                if (r_act && !i_ctl.skip) begin
                    r_r <= relax_r;
                    if (i_is_new) begin
                        r_c <= relax_r;
                    end
                end
            end
            C_P3: begin
                if (i_ctl.u_act && r_act && row_new != DIST_INF && row_new > r_mx) begin
                    r_mx <= row_new;
                end
            end
            C_SHIFT: begin
                if (i_mx_prev > r_mx) begin
                    r_mx <= i_mx_prev;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_c       = r_c;
    assign o_r       = r_r;
    assign o_mx      = r_mx;
    assign o_act     = r_act;
    assign o_row_new = row_new;
    assign o_col_new = col_new;

endmodule

FILE: hdl/incremental_all_pairs_shortest_path_top.sv
// Top level of the incremental all-pairs shortest-path engine.
//
//  channel   | ports                                              | handshake
//  ----------+----------------------------------------------------+-------------------------
//  command   | i_operation i_row i_col i_weight i_vertex          | start high, busy low
//  result    | o_max_distance                                     | o_valid, one cycle
//  config    | i_cfg_data (node_count)                            | i_cfg_we, one cycle
//
// A weight load leaves busy low. An accepted add holds busy through its phases
// (n = active vertices after the add): the weight column sweep, two store syncs
// and the final row/column pass each visit NODES rows of the row-wide stores,
// the two ordered relaxation passes visit n list positions, and the max is
// drained along the cell chain in NODES-1 hops.
// Reset clears the active set, the sequencer and node_count (to 64); the
// stores need no clearing. The result word comes in the first cycle with busy low.
module incremental_all_pairs_shortest_path_top import iapsp_pkg::*; #(
    parameter int NODES       = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_operation,
    input  logic [5:0]            i_row,
    input  logic [5:0]            i_col,
    input  logic [15:0]           i_weight,
    input  logic [5:0]            i_vertex,
    input  logic                  i_cfg_we,
    input  logic [NODE_CNT_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [DIST_W-1:0]     o_max_distance
);

    localparam int VB = $clog2(NODES);
    localparam int CB = $clog2(NODES + 1);
    localparam int WB = WEIGHT_BITS;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_LDR  = 11'b000_0000_0010,
        S_LDR2 = 11'b000_0000_0100,
        S_LDC  = 11'b000_0000_1000,
        S_SY1  = 11'b000_0001_0000,
        S_P1   = 11'b000_0010_0000,
        S_SY2  = 11'b000_0100_0000,
        S_P2   = 11'b000_1000_0000,
        S_P3   = 11'b001_0000_0000,
        S_DRN  = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    typedef logic [NODES-1:0][DIST_W-1:0] t_dvec;
    typedef logic [NODES-1:0][WB-1:0]     t_wvec;

    function automatic t_dist satw(input logic [WB-1:0] w);
        return (32'(w) >= 32'(DIST_INF)) ? DIST_INF : DIST_W'(w);
    endfunction

    t_state r_state, n_state;
    logic [CB-1:0] r_cnt;
    logic [CB-1:0] r_count;
    logic [NODE_CNT_W-1:0] r_node_count;
    logic [VB-1:0] r_xi;
    logic [VB-1:0] r_order [NODES];
    logic [VB-1:0] r_ord_q;
    logic          r_p1_vld;
    logic [VB-1:0] r_p1_idx;
    logic          r_p2_vld;
    logic [VB-1:0] r_p2_vtx;
    logic          r_ovld;
    t_dist         r_omax;

    logic          idle_acc;
    logic          load_acc;
    logic          add_acc;
    logic [CB-1:0] lim;
    logic          sweep;
    logic          rd_state;
    logic          issue;
    logic          done;
    logic [VB-1:0] vidx;
    logic [NODES-1:0] xi_mask;

    // Memory ports.
    logic          rm_we, cm_we, w_we;
    logic [VB-1:0] rm_waddr, cm_waddr, w_waddr;
    logic [NODES-1:0] rm_wmask, cm_wmask, w_wmask;
    t_dvec         rm_wdata, cm_wdata;
    t_wvec         w_wdata;
    logic [VB-1:0] rm_raddr, cm_raddr, w_raddr;
    t_dvec         rm_rdata, cm_rdata;
    t_wvec         w_rdata;

    // Cell chain wires.
    t_cell_ctl     ctl;
    t_dvec         c_all, r_all, mx_all, row_new, col_new, lane_a, w_sat;
    logic [NODES-1:0] act_all, sel, is_new;
    logic [VB-1:0] sel_idx;

    assign idle_acc = start && !busy;
    assign load_acc = idle_acc && i_operation == OP_LOAD
                      && 32'(i_row) < NODES && 32'(i_col) < NODES;
    assign add_acc  = idle_acc && i_operation == OP_ADD && 32'(i_vertex) < NODES
                      && 32'(r_count) < 32'(r_node_count) && 32'(r_count) < NODES;

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_ovld;
    assign o_max_distance = r_omax;
    assign vidx           = r_cnt[VB-1:0];
    assign xi_mask        = NODES'(1) << r_xi;

    // Sweep length and pipeline bookkeeping per phase.
    always_comb begin
        lim      = '0;
        sweep    = 1'b0;
        rd_state = 1'b0;
        case (r_state)
            S_LDC: begin
                lim = CB'(NODES); sweep = 1'b1; rd_state = 1'b1;
            end
            S_SY1, S_SY2: begin
                lim = CB'(NODES); sweep = 1'b1;
            end
            S_P1, S_P2: begin
                lim = r_count; sweep = 1'b1; rd_state = 1'b1;
            end
            S_P3: begin
                lim = CB'(NODES); sweep = 1'b1; rd_state = 1'b1;
            end
            S_DRN: begin
                lim = CB'(NODES - 1); sweep = 1'b1;
            end
            default: begin
            end
        endcase
        issue = sweep && (r_cnt < lim);
        done  = sweep && (r_cnt == lim) && !r_p1_vld && !r_p2_vld;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (add_acc) n_state = S_LDR;
            S_LDR:  n_state = S_LDR2;
            S_LDR2: n_state = S_LDC;
            S_LDC:  if (done) n_state = S_SY1;
            S_SY1:  if (done) n_state = S_P1;
            S_P1:   if (done) n_state = S_SY2;
            S_SY2:  if (done) n_state = S_P2;
            S_P2:   if (done) n_state = S_P3;
            S_P3:   if (done) n_state = S_DRN;
            S_DRN:  if (done) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_count      <= '0;
            r_node_count <= NODE_CNT_RESET;
            r_p1_vld     <= 1'b0;
            r_p2_vld     <= 1'b0;
            r_ovld       <= 1'b0;
        end else begin
            r_state  <= n_state;
            // advance the sweep, restart it on every phase change
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_p1_vld <= issue && rd_state;
            r_p2_vld <= r_p1_vld && (r_state == S_P1 || r_state == S_P2);
            if (add_acc) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            r_ovld <= (r_state == S_OUT);
        end
    end

    // Payload registers: order list, pipeline tags, result.
    always_ff @(posedge i_clk) begin
        if (add_acc) begin
            r_xi                    <= VB'(i_vertex);
            r_order[r_count[VB-1:0]] <= VB'(i_vertex);
        end
        r_ord_q  <= r_order[vidx];
        r_p1_idx <= vidx;
        r_p2_vtx <= r_ord_q;
        if (r_state == S_OUT) begin
            r_omax <= mx_all[NODES-1];
        end
    end

    // Read address selection.
    always_comb begin
        w_raddr  = (r_state == S_LDC) ? vidx : r_xi;
        cm_raddr = (r_state == S_P1) ? r_ord_q : vidx;
        rm_raddr = (r_state == S_P2) ? r_ord_q : vidx;
    end

    // Write port selection: weight loads, syncs of the new row/column, final pass.
    always_comb begin
        w_we     = load_acc;
        w_waddr  = VB'(i_row);
        w_wmask  = NODES'(1) << VB'(i_col);
        w_wdata  = {NODES{WB'(i_weight)}};

        rm_we    = 1'b0;
        rm_waddr = vidx;
        rm_wmask = '0;
        rm_wdata = {NODES{DIST_INF}};
        cm_we    = 1'b0;
        cm_waddr = vidx;
        cm_wmask = '0;
        cm_wdata = {NODES{DIST_INF}};

        if (load_acc) begin
            rm_we    = 1'b1;
            rm_waddr = VB'(i_row);
            rm_wmask = NODES'(1) << VB'(i_col);
            cm_we    = 1'b1;
            cm_waddr = VB'(i_col);
            cm_wmask = NODES'(1) << VB'(i_row);
        end else if ((r_state == S_SY1 || r_state == S_SY2) && issue) begin
            rm_we = 1'b1;
            cm_we = 1'b1;
            if (vidx == r_xi) begin
                rm_wmask = '1;
                rm_wdata = r_all;
                cm_wmask = '1;
                cm_wdata = c_all;
            end else begin
                rm_wmask = xi_mask;
                rm_wdata = {NODES{c_all[vidx]}};
                cm_wmask = xi_mask;
                cm_wdata = {NODES{r_all[vidx]}};
            end
        end else if (r_state == S_P3 && r_p1_vld) begin
            rm_we    = 1'b1;
            rm_waddr = r_p1_idx;
            rm_wmask = '1;
            rm_wdata = row_new;
            cm_we    = 1'b1;
            cm_waddr = r_p1_idx;
            cm_wmask = '1;
            cm_wdata = col_new;
        end
    end

    // Broadcast command to the cell chain.
    always_comb begin
        ctl       = '{op: C_NOP, sa: '0, sb: '0, skip: 1'b0, u_new: 1'b0, u_act: 1'b0};
        sel_idx   = r_p1_idx;
        case (r_state)
            S_IDLE: begin
                sel_idx = VB'(i_vertex);
                if (add_acc) ctl.op = C_ADD;
            end
            S_LDR2: ctl.op = C_LOADR;
            S_LDC: begin
                if (r_p1_vld) ctl.op = C_LOADC;
                ctl.sa = satw(w_rdata[r_xi]);
            end
            S_P1: begin
                if (r_p2_vld) ctl.op = C_P1;
                ctl.sa   = c_all[r_p2_vtx];
                ctl.skip = (r_p2_vtx == r_xi);
            end
            S_P2: begin
                if (r_p2_vld) ctl.op = C_P2;
                ctl.sa   = r_all[r_p2_vtx];
                ctl.skip = (r_p2_vtx == r_xi);
            end
            S_P3: begin
                if (r_p1_vld) ctl.op = C_P3;
                ctl.sa    = c_all[r_p1_idx];
                ctl.sb    = r_all[r_p1_idx];
                ctl.u_new = (r_p1_idx == r_xi);
                ctl.u_act = act_all[r_p1_idx];
            end
            S_DRN: begin
                if (issue) ctl.op = C_SHIFT;
            end
            default: begin
            end
        endcase
    end

    // Per-lane inputs and the chain of cells; the max hops one cell per cycle.
    for (genvar v = 0; v < NODES; v++) begin : g_cell
        assign w_sat[v]  = satw(w_rdata[v]);
        assign sel[v]    = (VB'(v) == sel_idx);
        assign is_new[v] = (VB'(v) == r_xi);
        assign lane_a[v] = (r_state == S_LDR2) ? w_sat[v] :
                           (r_state == S_P1)   ? cm_rdata[v] : rm_rdata[v];

        iapsp_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_sel     (sel[v]),
            .i_is_new  (is_new[v]),
            .i_lane_a  (lane_a[v]),
            .i_lane_b  (cm_rdata[v]),
            .i_mx_prev ((v == 0) ? t_dist'(0) : mx_all[(v == 0) ? 0 : v - 1]),
            .o_c       (c_all[v]),
            .o_r       (r_all[v]),
            .o_mx      (mx_all[v]),
            .o_act     (act_all[v]),
            .o_row_new (row_new[v]),
            .o_col_new (col_new[v])
        );
    end

    // Weight store, row-major distance store and column-major distance store.
    iapsp_lane_mem #(.DEPTH(NODES), .LANES(NODES), .DW(WB), .AW(VB)) u_wmem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wmask(w_wmask),
        .i_wdata(w_wdata), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    iapsp_lane_mem #(.DEPTH(NODES), .LANES(NODES), .DW(DIST_W), .AW(VB)) u_rmem (
        .i_clk(i_clk), .i_we(rm_we), .i_waddr(rm_waddr), .i_wmask(rm_wmask),
        .i_wdata(rm_wdata), .i_raddr(rm_raddr), .o_rdata(rm_rdata)
    );

    iapsp_lane_mem #(.DEPTH(NODES), .LANES(NODES), .DW(DIST_W), .AW(VB)) u_cmem (
        .i_clk(i_clk), .i_we(cm_we), .i_waddr(cm_waddr), .i_wmask(cm_wmask),
        .i_wdata(cm_wdata), .i_raddr(cm_raddr), .o_rdata(cm_rdata)
    );

    // A result word only ever follows the output state.
    a_valid_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_OUT))
        else $error("result strobe without output state");

    // The active set never outgrows the vertex count.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(NODES))
        else $error("active count overflow");

    // An accepted add always launches the row copy.
    a_add_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add_acc |=> (r_state == S_LDR))
        else $error("add accepted without starting");

endmodule
